@@ src/assert_macros.svh @@
// Assertion macros shared by the checker files.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active (low).
`define BDMP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active (low).
`define BDMP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/bdmp_pkg.sv @@
// Shared types, register indexes and widths for the button debounce block.
// No dependencies.
package bdmp_pkg;

    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned S_TDATA_W  = 40;
    localparam int unsigned M_TDATA_W  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_STABLE_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_WINDOW     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_TARGET     = 2'd2;

    localparam logic [7:0]  THRESHOLD_RESET = 8'd5;
    localparam logic [15:0] WINDOW_RESET    = 16'd1000;
    localparam logic [3:0]  TARGET_RESET    = 4'd3;
    localparam logic [3:0]  COUNT_MAX       = 4'd15;

    typedef struct packed {
        logic [7:0]  stable_sample_threshold;
        logic [15:0] press_window_ms;
        logic [3:0]  press_count_target;
    } cfg_t;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        button_level;
    } in_item_t;

    typedef struct packed {
        logic [3:0] press_count;
        logic       multi_press_trigger;
        logic       press_seen;
        logic       stable_level;
    } out_item_t;

    // Pipeline control between the stages.
    typedef struct packed {
        logic valid;
        logic advance;
    } stage_ctl_t;

endpackage

@@ src/bdmp_in_reg.sv @@
// Input register stage: captures one sample request from the input channel.
// Depends on bdmp_pkg.
module bdmp_in_reg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           load,
    input  logic                           drain,
    input  logic [bdmp_pkg::S_TDATA_W-1:0] s_data,
    output logic                           valid,
    output bdmp_pkg::in_item_t             item
);
    import bdmp_pkg::*;

    logic     valid_reg, valid_next;
    in_item_t item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (drain) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg.button_level <= s_data[0];
            item_reg.now_ms       <= s_data[32:1];
        end
    end

    assign valid = valid_reg;
    assign item  = item_reg;

endmodule

@@ src/bdmp_core.sv @@
// Debounce and multi-press state with its combinational update, registered when a sample advances.
// Depends on bdmp_pkg.
module bdmp_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bdmp_pkg::stage_ctl_t ctl,
    input  bdmp_pkg::cfg_t       cfg,
    input  bdmp_pkg::in_item_t   item,
    output bdmp_pkg::out_item_t  result
);
    import bdmp_pkg::*;

    logic        prev_sample_reg, prev_sample_next;
    logic [7:0]  run_count_reg, run_count_next;
    logic        deb_level_reg, deb_level_next;
    logic [3:0]  press_count_reg, press_count_next;
    logic [31:0] last_press_reg, last_press_next;

    logic [7:0]  run_inc;
    logic [31:0] gap_ms;
    logic [3:0]  count_inc;
    logic        pressed;
    logic        trigger;

    always_comb begin
        run_inc          = run_count_reg + 8'd1;
        gap_ms           = item.now_ms - last_press_reg;
        count_inc        = (press_count_reg < COUNT_MAX) ? press_count_reg + 4'd1 : COUNT_MAX;
        prev_sample_next = item.button_level;
        run_count_next   = run_count_reg;
        deb_level_next   = deb_level_reg;
        press_count_next = press_count_reg;
        last_press_next  = last_press_reg;
        pressed          = 1'b0;
        trigger          = 1'b0;

        if (item.button_level != prev_sample_reg) begin
            run_count_next = 8'd0;
        end else if (run_count_reg < cfg.stable_sample_threshold) begin
            run_count_next = run_inc;
            if (run_inc == cfg.stable_sample_threshold &&
                item.button_level != deb_level_reg) begin
                deb_level_next = item.button_level;
                if (!item.button_level) begin
                    pressed         = 1'b1;
                    last_press_next = item.now_ms;
                    // Restart when idle or the gap since the last press is too long.
                    if (press_count_reg == 4'd0 ||
                        gap_ms > {16'd0, cfg.press_window_ms}) begin
                        press_count_next = 4'd1;
                    end else if (count_inc == cfg.press_count_target) begin
                        trigger          = 1'b1;
                        press_count_next = 4'd0;
                    end else begin
                        press_count_next = count_inc;
                    end
                end
            end
        end

        result.stable_level        = deb_level_next;
        result.press_seen          = pressed;
        result.multi_press_trigger = trigger;
        result.press_count         = press_count_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_sample_reg <= 1'b1;
            run_count_reg   <= 8'd0;
            deb_level_reg   <= 1'b1;
            press_count_reg <= 4'd0;
        end else if (ctl.advance) begin
            prev_sample_reg <= prev_sample_next;
            run_count_reg   <= run_count_next;
            deb_level_reg   <= deb_level_next;
            press_count_reg <= press_count_next;
        end
    end

    // Only read while the count is nonzero, which follows a write.
    always_ff @(posedge aclk) begin
        if (ctl.advance) begin
            last_press_reg <= last_press_next;
        end
    end

endmodule

@@ src/bdmp_out_reg.sv @@
// Result register stage: holds one result request until the sink takes it.
// Depends on bdmp_pkg.
module bdmp_out_reg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  bdmp_pkg::stage_ctl_t           ctl,
    input  bdmp_pkg::out_item_t            result,
    input  logic                           m_ready,
    output logic                           m_valid,
    output logic [bdmp_pkg::M_TDATA_W-1:0] m_data
);
    import bdmp_pkg::*;

    logic      valid_reg, valid_next;
    out_item_t data_reg;

    always_comb begin
        valid_next = valid_reg;
        if (ctl.advance) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.advance) begin
            data_reg <= result;
        end
    end

    assign m_valid = valid_reg;
    assign m_data  = {1'b0, data_reg};

endmodule

@@ src/button_debounce_multi_press_top.sv @@
// Button debounce and multi-press detector, top level.
// Depends on bdmp_pkg, bdmp_in_reg, bdmp_core and bdmp_out_reg.
//
// Each input request is one sample of an active-low button pin plus the
// current millisecond time; each yields exactly one result request with the
// debounced level, a press strobe, a multi-press trigger and the running
// press count. The block takes one request per cycle and keeps that rate
// while results are taken every cycle: a sample moves from the input
// register through the combinational state update into the result register,
// and a stalled result keeps the next sample in the input register. The state
// update (run counter, debounced level, press count, last press time) is a
// single pass of compare/add logic whose longest path is the 32-bit
// wrapping time difference and its compare against the window. Input
// ready depends combinationally on output ready. Configuration writes go
// to cfg_index 0 (stable threshold, 8 bits), 1 (press window in ms,
// 16 bits) and 2 (press target, 4 bits); index 3 is ignored. Write only
// when the block is idle.
module button_debounce_multi_press_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Configuration write port
    input  logic                            cfg_we,
    input  logic [bdmp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [bdmp_pkg::CFG_DATA_W-1:0] cfg_wdata,
    // Input stream
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // tdata: [0] button_level, [32:1] now_ms, [39:33] zero
    input  logic [bdmp_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    // Result stream
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tdata: [0] stable_level, [1] press_seen, [2] multi_press_trigger,
    //        [6:3] press_count, [7] zero
    output logic [bdmp_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import bdmp_pkg::*;

    cfg_t       cfg_reg;
    stage_ctl_t ctl;
    in_item_t   in_item;
    out_item_t  result;
    logic       in_valid;
    logic       in_load;

    // Configuration registers; the user must write them only while idle, the block itself does not enforce this.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.stable_sample_threshold <= THRESHOLD_RESET;
            cfg_reg.press_window_ms         <= WINDOW_RESET;
            cfg_reg.press_count_target      <= TARGET_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_STABLE_THRESHOLD: cfg_reg.stable_sample_threshold <= cfg_wdata[7:0];
                REG_PRESS_WINDOW:     cfg_reg.press_window_ms         <= cfg_wdata;
                REG_PRESS_TARGET:     cfg_reg.press_count_target      <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // A sample advances when the result slot is free or being emptied.
    assign ctl.valid     = in_valid;
    assign ctl.advance   = in_valid && (!m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !in_valid || ctl.advance;
    assign in_load       = s_axis_tvalid && s_axis_tready;

    bdmp_in_reg u_in_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .load    (in_load),
        .drain   (ctl.advance),
        .s_data  (s_axis_tdata),
        .valid   (in_valid),
        .item    (in_item)
    );

    bdmp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .cfg     (cfg_reg),
        .item    (in_item),
        .result  (result)
    );

    bdmp_out_reg u_out_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (ctl),
        .result  (result),
        .m_ready (m_axis_tready),
        .m_valid (m_axis_tvalid),
        .m_data  (m_axis_tdata)
    );

endmodule

@@ src/bdmp_checker.sv @@
// Port-level checker for the button debounce block, bound to the top level.
// Depends on bdmp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bdmp_port_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            cfg_we,
    input logic [bdmp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [bdmp_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input logic                            s_axis_tvalid,
    input logic                            s_axis_tready,
    input logic [bdmp_pkg::S_TDATA_W-1:0]  s_axis_tdata,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [bdmp_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
    import bdmp_pkg::*;

    logic       r_stable;
    logic       r_press;
    logic       r_trig;
    logic [3:0] r_count;

    assign r_stable = m_axis_tdata[0];
    assign r_press  = m_axis_tdata[1];
    assign r_trig   = m_axis_tdata[2];
    assign r_count  = m_axis_tdata[6:3];

    // Stalled result holds.
    `BDMP_ASSERT_NXT(a_out_hold, aclk, aresetn,
        m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
    // Trigger only comes with a press.
    `BDMP_ASSERT_IMP(a_trig_press, aclk, aresetn,
        m_axis_tvalid && r_trig, r_press, "trigger without press")
    // Trigger clears the count.
    `BDMP_ASSERT_IMP(a_trig_clear, aclk, aresetn,
        m_axis_tvalid && r_trig, r_count == 4'd0, "count not cleared on trigger")
    // A press means the debounced level just went low.
    `BDMP_ASSERT_IMP(a_press_low, aclk, aresetn,
        m_axis_tvalid && r_press, !r_stable, "press with high level")
    // A press without trigger leaves a nonzero count.
    `BDMP_ASSERT_IMP(a_press_count, aclk, aresetn,
        m_axis_tvalid && r_press && !r_trig, r_count != 4'd0, "press left zero count")

endmodule

bind button_debounce_multi_press_top bdmp_port_checker u_bdmp_checker (.*);
